@@ hdl/i2cms_pkg.sv @@
package i2cms_pkg;

  // Field widths
  localparam int LEN_W      = 10;
  localparam int DATA_W     = 8;
  localparam int ADDR_W     = 7;
  localparam int MS_W       = 8;
  localparam int KIND_W     = 3;
  localparam int CMD_W      = KIND_W + DATA_W;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 24;
  localparam int M_TUSER_W  = 2;

  // Longest transfer; longer requests are cut to this
  localparam int MAX_TRANSFER = 512;

  // Mode codes on the input tuser
  localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SLOT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RX    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TICK  = 3'd4;

  // Command kinds, bits 10..8 of the command word
  localparam logic [KIND_W-1:0] KIND_SEND  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NACK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_START = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STOP  = 3'd6;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WR_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RD_LIMIT = 2'd2;
  localparam logic [ADDR_W-1:0]    DEV_ADDR_RST = 7'd40;
  localparam logic [MS_W-1:0]      WR_LIMIT_RST = 8'd5;
  localparam logic [MS_W-1:0]      RD_LIMIT_RST = 8'd10;

  // Queue geometry
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ,
    OP_SLOT,
    OP_RX,
    OP_TICK
  } op_t;

  typedef enum logic [2:0] {
    PH_START_TX = 3'd0,
    PH_DATA_TX  = 3'd1,
    PH_STOP_TX  = 3'd2,
    PH_START_RX = 3'd3,
    PH_DATA_RX  = 3'd4,
    PH_STOP_RX  = 3'd5,
    PH_DONE     = 3'd6
  } phase_t;

  // Classified item between front and back
  typedef struct packed {
    op_t               op;
    logic [LEN_W-1:0]  len;
    logic              stop;
    logic [DATA_W-1:0] data;
  } item_t;

  // One result item
  typedef struct packed {
    logic              cmd_valid;
    logic [CMD_W-1:0]  cmd_word;
    logic              rx_valid;
    logic [DATA_W-1:0] rx_byte;
    logic              rx_last;
    logic              write_refused;
    logic              done_res;
    logic              timeout_error;
  } result_t;

  // Register write from the config port
  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Zero counts as one, above the maximum is cut to the maximum
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] n;
    n = raw;
    if (n == '0) n = LEN_W'(1);
    if (32'(n) > MAX_TRANSFER) n = LEN_W'(MAX_TRANSFER);
    return n;
  endfunction

endpackage

@@ hdl/i2cms_front.sv @@
module i2cms_front (
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata: transfer_length[9:0], with_stop[10], data_byte[18:11], zero fill
  input  logic [i2cms_pkg::S_TDATA_W-1:0]  s_tdata,
  // s_tuser: mode[2:0]
  input  logic [i2cms_pkg::MODE_W-1:0]     s_tuser,
  output logic                             push_valid,
  output i2cms_pkg::item_t                 push_item,
  input  logic                             push_ready
);
  import i2cms_pkg::*;

  logic [LEN_W-1:0]  raw_len;
  logic [DATA_W-1:0] raw_data;

  assign raw_len  = s_tdata[LEN_W-1:0];
  assign raw_data = s_tdata[LEN_W+DATA_W:LEN_W+1];

  // Decode mode and normalize length before queueing
  always_comb begin
    push_item.len  = clamp_len(raw_len);
    push_item.stop = s_tdata[LEN_W];
    push_item.data = raw_data;
    case (s_tuser)
      MODE_WRITE: push_item.op = OP_WRITE;
      MODE_READ:  push_item.op = OP_READ;
      MODE_SLOT:  push_item.op = OP_SLOT;
      MODE_RX:    push_item.op = OP_RX;
      MODE_TICK:  push_item.op = OP_TICK;
      default:    push_item.op = OP_NONE;
    endcase
  end

  assign push_valid = s_tvalid;
  assign s_tready   = push_ready;

endmodule

@@ hdl/i2cms_queue.sv @@
module i2cms_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  i2cms_pkg::item_t push_item,
  output logic             push_ready,
  output logic             pop_valid,
  output i2cms_pkg::item_t pop_item,
  input  logic             pop_ready
);
  import i2cms_pkg::*;

  item_t                entry [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 push;
  logic                 pop;

  assign push_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entry[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ hdl/i2cms_back.sv @@
module i2cms_back (
  input  logic               clk,
  input  logic               rst,
  input  i2cms_pkg::cfg_wr_t cfg_wr,
  input  logic               pop_valid,
  input  i2cms_pkg::item_t   pop_item,
  output logic               pop_ready,
  output logic               out_valid,
  output i2cms_pkg::result_t res,
  input  logic               out_ready
);
  import i2cms_pkg::*;

  // Configuration
  logic [ADDR_W-1:0] dev_addr;
  logic [MS_W-1:0]   wr_limit;
  logic [MS_W-1:0]   rd_limit;

  // Sequencer state
  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  issued_count, issued_count_next;
  logic [LEN_W-1:0]  cmd_length, cmd_length_next;
  logic              stop_wanted, stop_wanted_next;
  logic [LEN_W-1:0]  received_count, received_count_next;
  logic [LEN_W-1:0]  receive_length, receive_length_next;
  logic              receiving, receiving_next;
  logic [MS_W-1:0]   stall_ms, stall_ms_next;

  result_t           res_next;
  logic              pop;

  // Shared conditions
  logic [LEN_W-1:0]  issued_inc;
  logic [LEN_W-1:0]  received_inc;
  logic [MS_W-1:0]   stall_inc;
  logic              write_ok;
  logic              data_end;
  logic              rx_ok;
  logic              rx_end;
  logic              tx_phase;
  logic              rd_hit;
  logic              wr_hit;

  assign pop_ready    = !out_valid || out_ready;
  assign pop          = pop_valid && pop_ready;
  assign issued_inc   = issued_count + 1'b1;
  assign received_inc = received_count + 1'b1;
  assign stall_inc    = (stall_ms == '1) ? stall_ms : stall_ms + 1'b1;
  assign write_ok     = (phase == PH_DONE) && !receiving;
  assign data_end     = (issued_inc >= cmd_length);
  assign rx_ok        = receiving && (received_count < receive_length);
  assign rx_end       = (received_inc >= receive_length);
  assign tx_phase     = (phase == PH_START_TX) || (phase == PH_DATA_TX) ||
                        (phase == PH_STOP_TX);
  assign rd_hit       = receiving && (stall_inc >= rd_limit);
  assign wr_hit       = !receiving && tx_phase && (stall_inc >= wr_limit);

  // Next state
  always_comb begin
    phase_next          = phase;
    issued_count_next   = issued_count;
    cmd_length_next     = cmd_length;
    stop_wanted_next    = stop_wanted;
    received_count_next = received_count;
    receive_length_next = receive_length;
    receiving_next      = receiving;
    stall_ms_next       = stall_ms;
    if (pop) begin
      case (pop_item.op)
        OP_WRITE: begin
          if (write_ok) begin
            phase_next        = PH_START_TX;
            cmd_length_next   = pop_item.len;
            issued_count_next = '0;
            stop_wanted_next  = pop_item.stop;
            stall_ms_next     = '0;
          end
        end
        OP_READ: begin
          phase_next          = PH_START_RX;
          cmd_length_next     = pop_item.len;
          issued_count_next   = '0;
          stop_wanted_next    = 1'b1;
          receive_length_next = pop_item.len;
          received_count_next = '0;
          receiving_next      = 1'b1;
          stall_ms_next       = '0;
        end
        OP_SLOT: begin
          case (phase)
            PH_START_TX: begin
              phase_next    = PH_DATA_TX;
              stall_ms_next = '0;
            end
            PH_DATA_TX: begin
              issued_count_next = issued_inc;
              stall_ms_next     = '0;
              if (data_end) phase_next = stop_wanted ? PH_STOP_TX : PH_DONE;
            end
            PH_STOP_TX: begin
              phase_next    = PH_DONE;
              stall_ms_next = '0;
            end
            PH_START_RX: phase_next = PH_DATA_RX;
            PH_DATA_RX: begin
              issued_count_next = issued_inc;
              if (data_end) phase_next = stop_wanted ? PH_STOP_RX : PH_DONE;
            end
            PH_STOP_RX: phase_next = PH_DONE;
            default: ;
          endcase
        end
        OP_RX: begin
          if (rx_ok) begin
            received_count_next = received_inc;
            stall_ms_next       = '0;
            if (rx_end) receiving_next = 1'b0;
          end
        end
        OP_TICK: begin
          if (receiving) begin
            stall_ms_next = stall_inc;
            if (rd_hit) begin
              receiving_next = 1'b0;
              stall_ms_next  = '0;
            end
          end else if (tx_phase) begin
            stall_ms_next = stall_inc;
            if (wr_hit) begin
              phase_next    = PH_DONE;
              stall_ms_next = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result for the popped item
  always_comb begin
    res_next = '0;
    case (pop_item.op)
      OP_WRITE: res_next.write_refused = !write_ok;
      OP_SLOT: begin
        case (phase)
          PH_START_TX: begin
            res_next.cmd_valid = 1'b1;
            res_next.cmd_word  = {KIND_START, dev_addr, 1'b0};
          end
          PH_DATA_TX: begin
            res_next.cmd_valid = 1'b1;
            res_next.cmd_word  = {KIND_SEND, pop_item.data};
            res_next.done_res  = data_end && !stop_wanted;
          end
          PH_STOP_TX, PH_STOP_RX: begin
            res_next.cmd_valid = 1'b1;
            res_next.cmd_word  = {KIND_STOP, {DATA_W{1'b0}}};
            res_next.done_res  = 1'b1;
          end
          PH_START_RX: begin
            res_next.cmd_valid = 1'b1;
            res_next.cmd_word  = {KIND_START, dev_addr, 1'b1};
          end
          PH_DATA_RX: begin
            res_next.cmd_valid = 1'b1;
            res_next.cmd_word  = {(data_end ? KIND_NACK : KIND_ACK), {DATA_W{1'b0}}};
            res_next.done_res  = data_end && !stop_wanted;
          end
          default: ;
        endcase
      end
      OP_RX: begin
        if (rx_ok) begin
          res_next.rx_valid = 1'b1;
          res_next.rx_byte  = pop_item.data;
          res_next.rx_last  = rx_end;
        end
      end
      OP_TICK: res_next.timeout_error = rd_hit || wr_hit;
      default: ;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= DEV_ADDR_RST;
      wr_limit <= WR_LIMIT_RST;
      rd_limit <= RD_LIMIT_RST;
    end else if (cfg_wr.en) begin
      case (cfg_wr.index)
        REG_DEV_ADDR: dev_addr <= cfg_wr.data[ADDR_W-1:0];
        REG_WR_LIMIT: wr_limit <= cfg_wr.data[MS_W-1:0];
        REG_RD_LIMIT: rd_limit <= cfg_wr.data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DONE;
      issued_count   <= '0;
      cmd_length     <= '0;
      stop_wanted    <= 1'b0;
      received_count <= '0;
      receive_length <= '0;
      receiving      <= 1'b0;
      stall_ms       <= '0;
    end else begin
      phase          <= phase_next;
      issued_count   <= issued_count_next;
      cmd_length     <= cmd_length_next;
      stop_wanted    <= stop_wanted_next;
      received_count <= received_count_next;
      receive_length <= receive_length_next;
      receiving      <= receiving_next;
      stall_ms       <= stall_ms_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res <= res_next;
  end

  // A result never carries a command and a received byte together
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res.cmd_valid && res.rx_valid))
    else $error("command and received byte in one result");

  // An active read never has its byte count at or past its length
  a_rx_bound: assert property (@(posedge clk) disable iff (rst)
    receiving |-> (received_count < receive_length))
    else $error("receive count reached length while receiving");

  // Issued commands never run past the transfer length
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issued_count <= cmd_length)
    else $error("issued count past command length");

  // A timeout always leaves the sequencer with no read in progress or idle
  a_timeout_ends: assert property (@(posedge clk) disable iff (rst)
    (pop && res_next.timeout_error) |=> (!receiving || phase == PH_DONE))
    else $error("timeout left transfer running");

endmodule

@@ hdl/i2c_master_fifo_sequencer.sv @@
// m_tvalid rises after an item is accepted: the item is stored in the command
// queue, popped into the output register and held there until taken.
// Throughput: one item per cycle while results are taken; one update per item.
// The two-entry queue lets input stall on its own while a result waits.
// Reset (rst, synchronous): sequencer idle, counters cleared, queue empty,
// registers back to address 40, write limit 5 ms, read limit 10 ms.
module i2c_master_fifo_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: transfer_length[9:0], with_stop[10], data_byte[18:11], zero fill
  input  logic [i2cms_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser: mode[2:0]
  input  logic [i2cms_pkg::MODE_W-1:0]      s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: cmd_word[10:0], rx_byte[18:11], write_refused[19], done_res[20],
  //          timeout_error[21], zero fill
  output logic [i2cms_pkg::M_TDATA_W-1:0]   m_tdata,
  // m_tuser: cmd_valid[0], rx_valid[1]
  output logic [i2cms_pkg::M_TUSER_W-1:0]   m_tuser,
  // m_tlast: rx_last
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cms_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2cms_pkg::*;

  logic    push_valid;
  logic    push_ready;
  item_t   push_item;
  logic    pop_valid;
  logic    pop_ready;
  item_t   pop_item;
  result_t res;
  cfg_wr_t cfg_wr;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.en    = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  i2cms_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  i2cms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  i2cms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_valid (m_tvalid),
    .res       (res),
    .out_ready (m_tready)
  );

  // Pack the result onto the output stream
  assign m_tdata = {2'b00, res.timeout_error, res.done_res, res.write_refused,
                    res.rx_byte, res.cmd_word};
  assign m_tuser = {res.rx_valid, res.cmd_valid};
  assign m_tlast = res.rx_last;

endmodule
